// ===== rtl/u8sd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types for the UTF-8 stream decoder
// Holds the queue entry that carries up to two decoded results per byte.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpWidth   = 32;
  localparam int unsigned ByteWidth = 8;

  // Byte classes seen by the front end
  typedef enum logic [1:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD,
    KIND_BAD
  } u8sd_kind_t;

  // One queue entry: the results caused by one input word.
  // The second result, when present, is never an error.
  typedef struct packed {
    logic [CpWidth-1:0] first_cp;
    logic               first_bad;
    logic               two;
    logic [CpWidth-1:0] second_cp;
  } u8sd_entry_t;

endpackage

// ===== rtl/u8sd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_front: byte classifier and accumulator
// Takes one byte per cycle unless the queue is full, updates the code point
// accumulator and pushes the byte's results into the result queue.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [u8sd_pkg::ByteWidth-1:0]      in_byte,
  input  logic                                in_last,
  input  logic                                q_full,
  output logic                                in_ready,
  output logic                                push,
  output u8sd_pkg::u8sd_entry_t               entry
);

  logic [u8sd_pkg::CpWidth-1:0] acc;
  logic [u8sd_pkg::CpWidth-1:0] acc_next;
  logic                         seen;
  logic [u8sd_pkg::CpWidth-1:0] new_val;
  logic [u8sd_pkg::ByteWidth-1:0] mask;
  u8sd_pkg::u8sd_kind_t         kind;
  logic                         emit_pend;
  logic                         emit_new;
  logic                         has_res;
  logic                         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mask = '0;
    unique case (in_byte) inside
      8'b0???????: kind = u8sd_pkg::KIND_ASCII;
      8'b10??????: kind = u8sd_pkg::KIND_CONT;
      8'b110?????: begin kind = u8sd_pkg::KIND_LEAD; mask = 8'h1F; end
      8'b1110????: begin kind = u8sd_pkg::KIND_LEAD; mask = 8'h0F; end
      8'b11110???: begin kind = u8sd_pkg::KIND_LEAD; mask = 8'h07; end
      8'b111110??: begin kind = u8sd_pkg::KIND_LEAD; mask = 8'h03; end
      8'b1111110?: begin kind = u8sd_pkg::KIND_LEAD; mask = 8'h01; end
      default:     kind = u8sd_pkg::KIND_BAD;
    endcase
  end

  always_comb begin
    new_val  = acc;
    emit_new = 1'b0;
    unique case (kind)
      u8sd_pkg::KIND_ASCII: begin
        new_val  = {{(u8sd_pkg::CpWidth-u8sd_pkg::ByteWidth){1'b0}}, in_byte};
        emit_new = in_last;
      end
      u8sd_pkg::KIND_CONT: begin
        // shift six payload bits in, wrapping at 32 bits
        new_val  = {acc[u8sd_pkg::CpWidth-7:0], in_byte[5:0]};
        emit_new = in_last;
      end
      u8sd_pkg::KIND_LEAD: begin
        new_val  = {{(u8sd_pkg::CpWidth-u8sd_pkg::ByteWidth){1'b0}}, in_byte & mask};
      end
      default: begin
        new_val  = acc;
      end
    endcase
    // only a lead (ASCII or multi-byte) flushes the pending value
    emit_pend = seen && ((kind == u8sd_pkg::KIND_ASCII) || (kind == u8sd_pkg::KIND_LEAD));
    has_res   = emit_pend || emit_new || (kind == u8sd_pkg::KIND_BAD);
    acc_next  = new_val;

    entry.first_bad = (kind == u8sd_pkg::KIND_BAD);
    entry.first_cp  = (kind == u8sd_pkg::KIND_BAD) ? '0 : (emit_pend ? acc : new_val);
    entry.two       = emit_pend && emit_new;
    entry.second_cp = new_val;
    push            = accept && has_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      seen <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        acc  <= '0;
        seen <= 1'b0;
      end else if (kind != u8sd_pkg::KIND_BAD) begin
        acc  <= acc_next;
        seen <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u8sd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_queue: result queue
// Small register FIFO between the classifier and the output stage.
// ----------------------------------------------------------------------------
module u8sd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8sd_pkg::u8sd_entry_t push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output u8sd_pkg::u8sd_entry_t head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u8sd_pkg::u8sd_entry_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u8sd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_back: output stage
// Holds one entry, sends its one or two results one per cycle with out_ready.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_not_empty,
  input  u8sd_pkg::u8sd_entry_t        q_head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u8sd_pkg::CpWidth-1:0] out_cp,
  output logic                         out_bad,
  output logic                         out_last
);

  u8sd_pkg::u8sd_entry_t cur;
  logic                  busy;
  logic                  second;
  logic                  finish;

  assign out_valid = busy;
  assign out_cp    = second ? cur.second_cp : cur.first_cp;
  assign out_bad   = !second && cur.first_bad;
  assign out_last  = second || !cur.two;
  assign finish    = busy && out_ready && out_last;
  assign pop       = q_not_empty && (!busy || finish);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (pop) begin
      busy   <= 1'b1;
      second <= 1'b0;
    end else if (finish) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (busy && out_ready) begin
      second <= 1'b1;
    end
  end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder: UTF-8 byte stream to code point decoder
// Input: one byte per word on the s_axis channel, tlast marks a string's
// last byte. Output: decoded code points on the m_axis channel, tuser flags
// an error word (input byte 0xFE or 0xFF, code point zero), tlast marks the
// final result caused by one input byte.
// Lead bytes of one- to six-byte forms are taken without validation; a
// 32-bit accumulator wraps. A lead byte flushes the pending value, a
// continuation on the string's last byte flushes the new value, and a
// multi-byte lead that ends a string is dropped.
// Throughput: one input word per cycle while results keep pace; a byte that
// yields two results sends them one after the other, absorbed by the result
// queue (DEPTH entries) between classifier and output stage.
// An accepted byte is first written into the queue, then loaded into the
// output stage, which raises m_axis_tvalid.
// Reset: rst (synchronous) empties the queue and clears the string state.
// A stalled receiver holds the current result; s_axis_tready drops only
// when the queue is full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // string_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] code_point
  output logic        m_axis_tuser,   // bad_byte
  output logic        m_axis_tlast    // run_last
);

  logic                  q_full;
  logic                  q_not_empty;
  logic                  push;
  logic                  pop;
  u8sd_pkg::u8sd_entry_t push_entry;
  u8sd_pkg::u8sd_entry_t head_entry;

  // Front: classify byte, update accumulator, emit queue entries
  u8sd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (push),
    .entry    (push_entry)
  );

  // Decoupling queue
  u8sd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_entry)
  );

  // Back: serialize one or two results per entry
  u8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (head_entry),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_cp      (m_axis_tdata),
    .out_bad     (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule
